### src/mtx4_pkg.sv
// Shared types, opcodes and the sequencer control store for the matrix multiplier.
package mtx4_pkg;

    localparam int DIM_DEF  = 4;
    localparam int FRAC_DEF = 16;

    localparam logic [1:0] OP_LDA = 2'd0;
    localparam logic [1:0] OP_LDB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_MAC   = 3'd1;
    localparam step_t STEP_DRN0  = 3'd2;
    localparam step_t STEP_DRN1  = 3'd3;
    localparam step_t STEP_FIN   = 3'd4;
    localparam step_t STEP_DONE  = 3'd5;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_IF_MUL,
        C_IF_K,
        C_IF_EL
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  issue;
        logic  emit;
        logic  swap;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic v;
        logic first;
    } mac_ctl_t;

    function automatic ucw_t mtx4_ucode(input step_t s);
        ucw_t w;
        w = '{accept: 1'b0, issue: 1'b0, emit: 1'b0, swap: 1'b0,
              cond: C_GOTO, target: STEP_IDLE};
        case (s)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = C_IF_MUL;
                w.target = STEP_MAC;
            end
            STEP_MAC:
            begin
                w.issue  = 1'b1;
                w.cond   = C_IF_K;
                w.target = STEP_MAC;
            end
            STEP_DRN0:
            begin
                w.cond = C_NEXT;
            end
            STEP_DRN1:
            begin
                w.cond = C_NEXT;
            end
            STEP_FIN:
            begin
                w.emit   = 1'b1;
                w.cond   = C_IF_EL;
                w.target = STEP_MAC;
            end
            STEP_DONE:
            begin
                w.swap   = 1'b1;
                w.cond   = C_GOTO;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = C_GOTO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### src/mtx4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtx4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mtx4_mac.sv
// Multiply-accumulate unit with round-to-nearest and 32-bit saturation.
module mtx4_mac #(
    parameter int DIM       = mtx4_pkg::DIM_DEF,
    parameter int FRAC_BITS = mtx4_pkg::FRAC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mtx4_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output logic signed [31:0]  res,
    output logic                sat
);
    import mtx4_pkg::*;

    localparam int SUM_W = 65 + $clog2(DIM);
    localparam logic signed [SUM_W:0] RND = (SUM_W+1)'(1) << (FRAC_BITS-1);

    logic signed [63:0]      prod_reg;
    logic signed [63:0]      prod_next;
    logic                    pv_reg;
    logic                    pf_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W:0]   rsum;
    logic signed [SUM_W:0]   shifted;
    logic [SUM_W-31:0]       hi;

    assign prod_next = a * b;

    always_comb
    begin
        sum_next = (pf_reg ? '0 : sum_reg) + {{(SUM_W-64){prod_reg[63]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            pf_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctl.v;
            pf_reg <= ctl.first;
        end
    end

    // Payload: no reset, hold when idle.
    always_ff @(posedge clk)
    begin
        if (ctl.v)
        begin
            prod_reg <= prod_next;
        end
        if (pv_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        rsum    = {sum_reg[SUM_W-1], sum_reg} + RND;
        shifted = rsum >>> FRAC_BITS;
        hi      = shifted[SUM_W:31];
        sat     = !((&hi) || !(|hi));
        if (sat)
        begin
            res = shifted[SUM_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            res = shifted[31:0];
        end
    end

endmodule

### src/matrix4x4_multiply.sv
// Top level of the fixed-point DIM x DIM matrix multiplier with microcoded control.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | opcode, row, col, value
//  res     | out       | res_valid / res_stall  | out_row, out_col, out_value, saturated, last
//
// A load is taken in the idle step. During a multiply, one shared
// multiply-accumulate unit does one product per cycle in the multiply step,
// plus the drain steps and the finish step per element that empty the
// read/multiply/add pipeline.
// Reset (rst_n, async, active low) clears control and marks both matrices zero
// through valid bits; no clearing pass is needed.
// A stalled result holds the sequencer at its finish step; loads keep flowing
// while the final result waits to transfer.
module matrix4x4_multiply #(
    parameter int DIM       = mtx4_pkg::DIM_DEF,
    parameter int FRAC_BITS = mtx4_pkg::FRAC_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [1:0]         opcode,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  logic signed [31:0] value,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         out_row,
    output logic [1:0]         out_col,
    output logic signed [31:0] out_value,
    output logic               saturated,
    output logic               last
);
    import mtx4_pkg::*;

    localparam int IDX_W  = $clog2(DIM);
    localparam int ELEM_W = 2 * IDX_W;
    localparam int ELEM_N = 1 << ELEM_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    // Sequencer state
    step_t              pc_reg, pc_next;
    logic [IDX_W-1:0]   r_reg, r_next;
    logic [IDX_W-1:0]   c_reg, c_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               bank_reg, bank_next;
    ucw_t               uw;

    // Read stage tags
    logic               rd_v_reg, rd_first_reg;
    logic               acc_ok_reg, acc_ok_next;
    logic               op_ok_reg, op_ok_next;

    // Element valid bits: a clear bit reads as zero
    logic [ELEM_N-1:0]  acc_vld_reg, acc_vld_next;
    logic [ELEM_N-1:0]  op_vld_reg, op_vld_next;

    // Result register
    logic               res_valid_reg, res_valid_next;
    logic [1:0]         res_row_reg, res_row_next;
    logic [1:0]         res_col_reg, res_col_next;
    logic signed [31:0] res_value_reg, res_value_next;
    logic               res_sat_reg, res_sat_next;
    logic               res_last_reg, res_last_next;

    // Control decode
    logic               accepted;
    logic               is_mul;
    logic               ld_ok;
    logic               ld_a, ld_b;
    logic               k_last, r_last, c_last, el_last;
    logic               hold;
    logic               emit_go;
    logic [IDX_W-1:0]   row_i, col_i;

    // RAM ports
    logic                acc_we;
    logic [ELEM_W:0]     acc_waddr;
    logic [31:0]         acc_wdata;
    logic [ELEM_W:0]     acc_raddr;
    logic [31:0]         acc_rdata;
    logic [ELEM_W-1:0]   op_raddr;
    logic [ELEM_W-1:0]   op_waddr;
    logic [31:0]         op_rdata;

    // MAC
    mac_ctl_t            mac_ctl;
    logic signed [31:0]  mac_a, mac_b;
    logic signed [31:0]  mac_res;
    logic                mac_sat;

    assign uw        = mtx4_ucode(pc_reg);
    assign cmd_stall = !uw.accept;
    assign accepted  = cmd_valid && uw.accept;
    assign is_mul    = accepted && (opcode == OP_MUL);

    // Drop loads that fall outside the matrix.
    assign ld_ok = (int'(row) < DIM) && (int'(col) < DIM);
    assign ld_a  = accepted && (opcode == OP_LDA) && ld_ok;
    assign ld_b  = accepted && (opcode == OP_LDB) && ld_ok;
    assign row_i = IDX_W'(row);
    assign col_i = IDX_W'(col);

    assign k_last  = (k_reg == LAST_IDX);
    assign r_last  = (r_reg == LAST_IDX);
    assign c_last  = (c_reg == LAST_IDX);
    assign el_last = r_last && c_last;

    // Hold the finish step while the result register is still waiting.
    assign hold    = uw.emit && res_valid_reg && res_stall;
    assign emit_go = uw.emit && !hold;

    // Next step
    always_comb
    begin
        case (uw.cond)
            C_NEXT:   pc_next = pc_reg + step_t'(1);
            C_GOTO:   pc_next = uw.target;
            C_IF_MUL: pc_next = is_mul ? uw.target : pc_reg;
            C_IF_K:   pc_next = k_last ? pc_reg + step_t'(1) : uw.target;
            C_IF_EL:
            begin
                if (hold)
                begin
                    pc_next = pc_reg;
                end
                else
                begin
                    pc_next = el_last ? pc_reg + step_t'(1) : uw.target;
                end
            end
            default:  pc_next = STEP_IDLE;
        endcase
    end

    // Index counters and bank flip
    always_comb
    begin
        k_next    = k_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        bank_next = bank_reg;
        if (uw.issue)
        begin
            k_next = k_last ? '0 : k_reg + IDX_W'(1);
        end
        if (emit_go)
        begin
            if (r_last)
            begin
                r_next = '0;
                c_next = c_last ? '0 : c_reg + IDX_W'(1);
            end
            else
            begin
                r_next = r_reg + IDX_W'(1);
            end
        end
        if (uw.swap)
        begin
            bank_next = !bank_reg;
        end
    end

    // Operand reads: acc[r][k] from the current bank, op[k][c].
    assign acc_raddr   = {bank_reg, r_reg, k_reg};
    assign op_raddr    = {k_reg, c_reg};
    assign acc_ok_next = acc_vld_reg[{r_reg, k_reg}];
    assign op_ok_next  = op_vld_reg[{k_reg, c_reg}];

    // New elements go to the other bank so later products still see the old matrix.
    always_comb
    begin
        acc_we = ld_a || emit_go;
        if (emit_go)
        begin
            acc_waddr = {!bank_reg, r_reg, c_reg};
            acc_wdata = mac_res;
        end
        else
        begin
            acc_waddr = {bank_reg, row_i, col_i};
            acc_wdata = value;
        end
    end

    assign op_waddr = {row_i, col_i};

    always_comb
    begin
        acc_vld_next = acc_vld_reg;
        op_vld_next  = op_vld_reg;
        if (ld_a)
        begin
            acc_vld_next[{row_i, col_i}] = 1'b1;
        end
        if (ld_b)
        begin
            op_vld_next[{row_i, col_i}] = 1'b1;
        end
        if (uw.swap)
        begin
            acc_vld_next = '1;
        end
    end

    mtx4_ram #(
        .WIDTH (32),
        .DEPTH (2 * ELEM_N)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (uw.issue),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    mtx4_ram #(
        .WIDTH (32),
        .DEPTH (ELEM_N)
    ) u_op_ram (
        .clk   (clk),
        .we    (ld_b),
        .waddr (op_waddr),
        .wdata (value),
        .re    (uw.issue),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    assign mac_ctl = '{v: rd_v_reg, first: rd_first_reg};
    assign mac_a   = acc_ok_reg ? acc_rdata : '0;
    assign mac_b   = op_ok_reg ? op_rdata : '0;

    mtx4_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .res   (mac_res),
        .sat   (mac_sat)
    );

    // Result register: load on finish, drop after transfer.
    always_comb
    begin
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_value_next = res_value_reg;
        res_sat_next   = res_sat_reg;
        res_last_next  = res_last_reg;
        if (emit_go)
        begin
            res_valid_next = 1'b1;
            res_row_next   = 2'(r_reg);
            res_col_next   = 2'(c_reg);
            res_value_next = mac_res;
            res_sat_next   = mac_sat;
            res_last_next  = el_last;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            bank_reg      <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            acc_vld_reg   <= '0;
            op_vld_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            bank_reg      <= bank_next;
            rd_v_reg      <= uw.issue;
            rd_first_reg  <= uw.issue && (k_reg == '0);
            acc_vld_reg   <= acc_vld_next;
            op_vld_reg    <= op_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.issue)
        begin
            acc_ok_reg <= acc_ok_next;
            op_ok_reg  <= op_ok_next;
        end
        res_row_reg   <= res_row_next;
        res_col_reg   <= res_col_next;
        res_value_reg <= res_value_next;
        res_sat_reg   <= res_sat_next;
        res_last_reg  <= res_last_next;
    end

    assign res_valid = res_valid_reg;
    assign out_row   = res_row_reg;
    assign out_col   = res_col_reg;
    assign out_value = res_value_reg;
    assign saturated = res_sat_reg;
    assign last      = res_last_reg;

    // Accept commands only with no product read in flight.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> !rd_v_reg)
        else $error("command accepted with a product read in flight");

    // Every element finishes with the inner index wrapped back to zero.
    a_fin_k_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_FIN) |-> (k_reg == '0))
        else $error("finish step reached with inner index not wrapped");

    // The final element is followed by the bank flip.
    a_last_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && el_last) |=> (pc_reg == STEP_DONE) && res_valid_reg && res_last_reg)
        else $error("final element not followed by bank flip");

endmodule
